FILE: rtl/multi_adc_frame_assembler_assert.svh
// Assertion macros shared by the checker files.
`ifndef MULTI_ADC_FRAME_ASSEMBLER_ASSERT_SVH
`define MULTI_ADC_FRAME_ASSEMBLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MAFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame assembler check failed");

// Next-cycle implication, disabled while reset is high.
`define MAFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame assembler check failed");

`endif

FILE: rtl/mafa_pkg.sv
package mafa_pkg;

   localparam int ADC_COUNT_DEFAULT        = 2;
   localparam int FRAME_SLOTS_DEFAULT      = 4;
   localparam int CHANNELS_PER_ADC_DEFAULT = 8;

   localparam int KIND_W   = 3;
   localparam int ADC_W    = 1;
   localparam int POS_W    = 4;
   localparam int WORD_W   = 24;
   localparam int RSLOT_W  = 2;
   localparam int FILLED_W = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_WORD      = 3'd0,
      KIND_START     = 3'd1,
      KIND_STOP      = 3'd2,
      KIND_NEW_FRAME = 3'd3,
      KIND_READ      = 3'd4
   } kind_type;

endpackage

FILE: rtl/multi_adc_frame_assembler.sv
// Frame assembler for several multi-channel ADCs. Each request beat carries one
// conversion word, a start/stop/new-frame command, or a read of a stored word;
// every request produces exactly one response beat with the frame status after
// that request and, for a valid read, the stored word (else zero). A request is
// taken every cycle; its response is registered and shows in the cycle after
// acceptance, and req_ready drops only while a response waits with rsp_ready
// low. The frame store is a single-port-write, single-read RAM of
// FRAME_SLOTS*ADC_COUNT*(CHANNELS_PER_ADC+2) words; a read of a word never
// written since power-up returns an undefined value.
module multi_adc_frame_assembler
   import mafa_pkg::*;
#(
   parameter int ADC_COUNT        = ADC_COUNT_DEFAULT,
   parameter int FRAME_SLOTS      = FRAME_SLOTS_DEFAULT,
   parameter int CHANNELS_PER_ADC = CHANNELS_PER_ADC_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ADC_W-1:0]    req_adc_index,
   input  logic [POS_W-1:0]    req_word_position,
   input  logic [WORD_W-1:0]   req_word_value,
   input  logic [RSLOT_W-1:0]  req_read_slot,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_frame_full,
   output logic                rsp_overrun,
   output logic                rsp_capture_running,
   output logic [FILLED_W-1:0] rsp_filled_slots,
   output logic [WORD_W-1:0]   rsp_read_word
);

   localparam int WORDS   = CHANNELS_PER_ADC + 2;
   localparam int CRC_POS = CHANNELS_PER_ADC + 1;
   localparam int DEPTH   = FRAME_SLOTS * ADC_COUNT * WORDS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SLOT_W  = $clog2(FRAME_SLOTS + 1);
   localparam int CNT_W   = (SLOT_W > FILLED_W) ? SLOT_W : FILLED_W;

   logic [WORD_W-1:0] store_mem [DEPTH];

   logic                 running_ff, running_in;
   logic                 ready_ff, ready_in;
   logic                 overrun_ff, overrun_in;
   logic                 accepting_ff, accepting_in;
   logic [CNT_W-1:0]     slot_ff, slot_in;
   logic [ADC_COUNT-1:0] received_ff, received_in;
   logic                 rsp_valid_ff;
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 rd_ok_ff, rd_ok_in;

   logic              req_fire;
   logic              adc_ok;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign adc_ok    = {31'b0, req_adc_index} < 32'(ADC_COUNT);

   assign wr_addr = ADDR_W'((int'(slot_ff) * ADC_COUNT + int'(req_adc_index)) * WORDS
                            + int'(req_word_position));
   assign rd_addr = ADDR_W'((int'(req_read_slot) * ADC_COUNT + int'(req_adc_index)) * WORDS
                            + int'(req_word_position));

   always_comb begin
      running_in   = running_ff;
      ready_in     = ready_ff;
      overrun_in   = overrun_ff;
      accepting_in = accepting_ff;
      slot_in      = slot_ff;
      received_in  = received_ff;
      wr_en        = 1'b0;
      rd_ok_in     = 1'b0;
      case (req_kind)
         KIND_WORD: begin
            if (adc_ok && req_word_position <= POS_W'(CRC_POS)) begin
               // status word decides whether the rest of the conversion is kept
               if (req_word_position == '0) begin
                  accepting_in = running_ff && (slot_ff < CNT_W'(FRAME_SLOTS));
                  if (!running_ff) begin
                     overrun_in = 1'b1;
                  end
               end
               if (accepting_in) begin
                  wr_en = slot_ff < CNT_W'(FRAME_SLOTS);
                  if (req_word_position == POS_W'(CRC_POS)) begin
                     accepting_in = 1'b0;
                     received_in  = received_ff | (ADC_COUNT'(1) << req_adc_index);
                     if (received_in == {ADC_COUNT{1'b1}}) begin
                        received_in = '0;
                        slot_in     = slot_ff + CNT_W'(1);
                     end
                     if (slot_in == CNT_W'(FRAME_SLOTS)) begin
                        ready_in = 1'b1;
                     end
                  end
               end
            end
         end
         KIND_START, KIND_STOP, KIND_NEW_FRAME: begin
            ready_in     = 1'b0;
            overrun_in   = 1'b0;
            slot_in      = '0;
            accepting_in = 1'b0;
            if (req_kind == KIND_START) begin
               running_in = 1'b1;
            end else if (req_kind == KIND_STOP) begin
               running_in = 1'b0;
            end
         end
         KIND_READ: begin
            rd_ok_in = ({30'b0, req_read_slot} < 32'(FRAME_SLOTS)) && adc_ok
                       && ({28'b0, req_word_position} < 32'(WORDS));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         ready_ff     <= 1'b0;
         overrun_ff   <= 1'b0;
         accepting_ff <= 1'b0;
         slot_ff      <= '0;
         received_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            running_ff   <= running_in;
            ready_ff     <= ready_in;
            overrun_ff   <= overrun_in;
            accepting_ff <= accepting_in;
            slot_ff      <= slot_in;
            received_ff  <= received_in;
            rd_ok_ff     <= rd_ok_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && wr_en) begin
         store_mem[wr_addr] <= req_word_value;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // status registers change only on an accepted beat, so they hold the result
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_full      = ready_ff;
   assign rsp_overrun         = overrun_ff;
   assign rsp_capture_running = running_ff;
   assign rsp_filled_slots    = slot_ff[FILLED_W-1:0];
   assign rsp_read_word       = rd_ok_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/mafa_checker.sv
`include "multi_adc_frame_assembler_assert.svh"

module mafa_checker
   import mafa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [KIND_W-1:0]   req_kind,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_frame_full,
   input logic                rsp_overrun,
   input logic                rsp_capture_running,
   input logic [FILLED_W-1:0] rsp_filled_slots,
   input logic [WORD_W-1:0]   rsp_read_word
);

   logic                         req_fire;
   logic                         rsp_stall;
   logic                         start_fire;
   logic                         status_cleared;
   logic [FILLED_W+WORD_W+2:0]   rsp_payload;

   assign req_fire       = req_valid && req_ready;
   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign start_fire     = req_fire && (req_kind == KIND_START);
   assign status_cleared = rsp_capture_running && !rsp_frame_full && !rsp_overrun
                           && (rsp_filled_slots == '0) && (rsp_read_word == '0);
   assign rsp_payload    = {rsp_frame_full, rsp_overrun, rsp_capture_running,
                            rsp_filled_slots, rsp_read_word};

   `MAFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))
   `MAFA_ASSERT_NEXT(a_beat_answered, clock, reset, req_fire, rsp_valid)
   `MAFA_ASSERT_NEXT(a_start_clears, clock, reset, start_fire, status_cleared)
   `MAFA_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_valid && rsp_overrun, !rsp_capture_running && !rsp_frame_full)

endmodule

bind multi_adc_frame_assembler mafa_checker u_mafa_checker (.*);
